>>> src/fbfl_pkg.sv
// Shared types and constants for the fixed block free list allocator.
package fbfl_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESET   = 2'd2,
    OP_INVALID = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_REJECT   = 2'd2,
    STAT_UNUSABLE = 2'd3
  } status_e;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_SWEEP = 1'b1
  } state_e;

  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SHIFT  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd2;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned COUNT_W = 11;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

  typedef struct packed {
    logic [ADDR_W-1:0]  block_address;
    status_e            status;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] available_count;
  } result_t;

endpackage

>>> src/fixed_block_free_list_allocator.sv
// Fixed-size block pool with a LIFO free list kept in a link memory.
//
// Input channel (in_valid_i / in_stall_o) carries an operation and an
// address: allocate pops the head block and returns its byte address, free
// maps an address to its block and pushes it, reset rebuilds the pool.
// Output channel (out_valid_o / out_stall_i) returns exactly one item per
// input item: block address, status and the allocated and available counts.
// The configuration port writes base address, block shift and block count.
// Allocate and free are done as their item is taken: the link of the
// current head is held in the registered read port of the link memory, so
// one item per cycle is sustained while in_stall_o is low. A result is
// registered in the output queue as its item is taken. A pool reset item on
// a usable pool, or a write of a nonzero block_count, starts a rebuild that
// relinks the usable entries (block_count, at most MAX_BLOCKS) one per cycle,
// and holds items off until it ends. Hardware reset leaves the pool unusable
// (block_count zero) and needs no rebuild. A two-entry output queue lets the
// block take an item while a result waits; in_stall_o rises only when both
// entries are full or during a rebuild.
module fixed_block_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] block_address_o,
  output logic [1:0]  status_o,
  output logic [10:0] used_count_o,
  output logic [10:0] available_count_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);

  fbfl_pkg::state_e state_q, state_d;

  logic [31:0] base_q;
  logic [4:0]  shift_q;
  logic [10:0] count_q;

  logic [IW-1:0] head_q, head_d;
  logic          head_ok_q, head_ok_d;
  logic [10:0]   used_q, used_d;
  logic [IW-1:0] sweep_idx_q, sweep_idx_d;

  logic [IW:0] link_mem [MAX_BLOCKS];
  logic [IW:0] link_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW:0]   mem_wd;

  logic [10:0] usable_n;
  logic [10:0] cfg_n;
  logic [4:0]  usable_sh;
  logic        in_accept;
  logic        cfg_count_wr;
  logic        pool_rst;
  logic        sweep_last;
  logic        sweep_we;
  fbfl_pkg::op_e     op;
  fbfl_pkg::result_t res;

  fbfl_pkg::result_t fifo_q [2];
  logic       fifo_wr_q, fifo_rd_q;
  logic [1:0] fifo_cnt_q;
  logic       fifo_pop;

  assign usable_n = ({21'b0, count_q} > 32'(MAX_BLOCKS)) ? 11'(MAX_BLOCKS) : count_q;
  assign cfg_n    = ({21'b0, cfg_data_i[10:0]} > 32'(MAX_BLOCKS)) ?
                    11'(MAX_BLOCKS) : cfg_data_i[10:0];
  assign usable_sh = (shift_q < fbfl_pkg::SHIFT_MIN) ? fbfl_pkg::SHIFT_MIN :
                     (shift_q > fbfl_pkg::SHIFT_MAX) ? fbfl_pkg::SHIFT_MAX : shift_q;

  assign op           = fbfl_pkg::op_e'(operation_i);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign cfg_count_wr = cfg_we_i && (cfg_index_i == fbfl_pkg::CFG_BLOCK_COUNT);
  assign pool_rst     = in_accept && (usable_n != '0) && (op == fbfl_pkg::OP_RESET);
  assign sweep_last   = (32'(sweep_idx_q) == (32'(usable_n) - 32'd1));

  always_comb begin
    state_d = state_q;
    priority if (cfg_count_wr) begin
      state_d = (cfg_n != '0) ? fbfl_pkg::ST_SWEEP : fbfl_pkg::ST_RUN;
    end else if (pool_rst) begin
      state_d = fbfl_pkg::ST_SWEEP;
    end else if (state_q == fbfl_pkg::ST_SWEEP && sweep_last) begin
      state_d = fbfl_pkg::ST_RUN;
    end
  end

  always_comb begin
    sweep_we   = (state_q == fbfl_pkg::ST_SWEEP);
    in_stall_o = (state_q == fbfl_pkg::ST_SWEEP) || (fifo_cnt_q == 2'd2);
  end

  always_comb begin
    logic [31:0] offset;
    logic [31:0] diff;
    logic [31:0] idx32;
    logic [10:0] used_t;

    offset = 32'(head_q) << usable_sh;
    diff   = address_i - base_q;
    idx32  = diff >> usable_sh;
    used_t = used_q;

    res                 = '0;
    res.status          = fbfl_pkg::STAT_OK;
    head_d              = head_q;
    head_ok_d           = head_ok_q;
    sweep_idx_d         = sweep_idx_q + IW'(1);
    mem_we              = sweep_we;
    mem_wa              = sweep_idx_q;
    mem_wd              = {sweep_idx_q != '0, sweep_idx_q - IW'(1)};

    if (in_accept) begin
      if (usable_n == '0) begin
        res.status = fbfl_pkg::STAT_UNUSABLE;
      end else begin
        unique case (op)
          fbfl_pkg::OP_ALLOC: begin
            if (!head_ok_q || (32'(head_q) >= 32'(usable_n))) begin
              res.status = fbfl_pkg::STAT_EMPTY;
            end else begin
              res.block_address = base_q + offset;
              head_d            = link_q[IW-1:0];
              head_ok_d         = link_q[IW];
              if (used_q < usable_n) begin
                used_t = used_q + 11'd1;
              end
            end
          end
          fbfl_pkg::OP_FREE: begin
            if ((address_i < base_q) || (idx32 >= {21'b0, usable_n})) begin
              res.status = fbfl_pkg::STAT_REJECT;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = idx32[IW-1:0];
              mem_wd    = {head_ok_q, head_q};
              head_d    = idx32[IW-1:0];
              head_ok_d = 1'b1;
              if (used_q != '0) begin
                used_t = used_q - 11'd1;
              end
            end
          end
          fbfl_pkg::OP_RESET: begin
            head_d      = IW'(32'(usable_n) - 32'd1);
            head_ok_d   = 1'b1;
            used_t      = '0;
            sweep_idx_d = '0;
          end
          fbfl_pkg::OP_INVALID: begin
            res.status = fbfl_pkg::STAT_REJECT;
          end
          default: begin
            res.status = fbfl_pkg::STAT_REJECT;
          end
        endcase
      end
    end

    used_d              = (used_t > usable_n) ? usable_n : used_t;
    res.used_count      = used_d;
    res.available_count = usable_n - used_d;

    if (cfg_count_wr) begin
      head_d      = IW'(32'(cfg_n) - 32'd1);
      head_ok_d   = (cfg_n != '0);
      used_d      = '0;
      sweep_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_we && (mem_wa == head_d)) begin
      link_q <= mem_wd;
    end else begin
      link_q <= link_mem[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbfl_pkg::ST_RUN;
      base_q      <= '0;
      shift_q     <= fbfl_pkg::SHIFT_MIN;
      count_q     <= '0;
      head_q      <= '0;
      head_ok_q   <= 1'b0;
      used_q      <= '0;
      sweep_idx_q <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      head_ok_q   <= head_ok_d;
      used_q      <= used_d;
      sweep_idx_q <= sweep_idx_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fbfl_pkg::CFG_BASE_ADDRESS: base_q  <= cfg_data_i;
          fbfl_pkg::CFG_BLOCK_SHIFT:  shift_q <= cfg_data_i[4:0];
          fbfl_pkg::CFG_BLOCK_COUNT:  count_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end

  assign fifo_pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fifo_q[fifo_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wr_q  <= 1'b0;
      fifo_rd_q  <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (in_accept) begin
        fifo_wr_q <= !fifo_wr_q;
      end
      if (fifo_pop) begin
        fifo_rd_q <= !fifo_rd_q;
      end
      fifo_cnt_q <= fifo_cnt_q + 2'(in_accept) - 2'(fifo_pop);
    end
  end

  assign out_valid_o       = (fifo_cnt_q != '0);
  assign block_address_o   = fifo_q[fifo_rd_q].block_address;
  assign status_o          = fifo_q[fifo_rd_q].status;
  assign used_count_o      = fifo_q[fifo_rd_q].used_count;
  assign available_count_o = fifo_q[fifo_rd_q].available_count;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= usable_n)
    else $error("allocated count exceeds pool size");

  a_head_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbfl_pkg::ST_RUN) && head_ok_q |-> (32'(head_q) < 32'(usable_n)))
    else $error("valid list head outside pool");

  a_pop_follows_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (op == fbfl_pkg::OP_ALLOC) && (res.status == fbfl_pkg::STAT_OK)
    && !cfg_count_wr |=> (head_q == $past(link_q[IW-1:0])) && (head_ok_q == $past(link_q[IW])))
    else $error("head not taken from link of popped block");

  a_queue_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= 2'd2)
    else $error("output queue overflow");

  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbfl_pkg::ST_SWEEP) |-> !in_accept && !(mem_we && (mem_wa != sweep_idx_q)))
    else $error("item or stray write during rebuild");

endmodule
